### rtl/rif_pkg.sv
package rif_pkg;

   localparam int CHANNEL_BITS = 8;
   localparam int CHANNELS = 3;
   localparam int CH_RED = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_BLUE = 2;

   localparam int CFG_MODE_BITS = 3;
   localparam int CFG_WIDTH_BITS = 11;
   localparam int CFG_HEIGHT_BITS = 16;
   localparam int CFG_MAXC_BITS = 8;

   localparam logic [CFG_MODE_BITS-1:0] MODE_RESET = 3'd0;
   localparam logic [CFG_WIDTH_BITS-1:0] WIDTH_RESET = 11'd640;
   localparam logic [CFG_HEIGHT_BITS-1:0] HEIGHT_RESET = 16'd480;
   localparam logic [CFG_MAXC_BITS-1:0] MAXC_RESET = 8'd255;

   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   // signed kernel sum, and its magnitude once clamped at zero
   localparam int KSUM_BITS = 13;
   localparam int KMAG_BITS = KSUM_BITS - 1;
   localparam int GSUM_BITS = CHANNEL_BITS + 2;

   // reciprocal multipliers, exact over the ranges in use
   localparam logic [11:0] DIV9_MUL = 12'd3641;
   localparam int DIV9_SHIFT = 15;
   localparam logic [9:0] DIV3_MUL = 10'd683;
   localparam int DIV3_SHIFT = 11;

   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

   typedef enum logic [CFG_MODE_BITS-1:0] {
      MODE_NONE    = 3'd0,
      MODE_GRAY    = 3'd1,
      MODE_EMBOSS  = 3'd2,
      MODE_EDGE    = 3'd3,
      MODE_BLUR    = 3'd4,
      MODE_INVERT  = 3'd5,
      MODE_SHARPEN = 3'd6
   } filter_mode_type;

   typedef enum logic [1:0] {
      REG_FILTER_MODE  = 2'd0,
      REG_IMAGE_WIDTH  = 2'd1,
      REG_IMAGE_HEIGHT = 2'd2,
      REG_MAX_COLOR    = 2'd3
   } csr_reg_type;

   typedef struct packed {
      logic [CHANNEL_BITS-1:0] red_in;
      logic [CHANNEL_BITS-1:0] green_in;
      logic [CHANNEL_BITS-1:0] blue_in;
      logic                    drain;
   } req_item_type;

   typedef struct packed {
      logic [CHANNEL_BITS-1:0] red_out;
      logic [CHANNEL_BITS-1:0] green_out;
      logic [CHANNEL_BITS-1:0] blue_out;
      logic                    frame_end;
   } rsp_item_type;

   typedef logic [CHANNELS-1:0][CHANNEL_BITS-1:0] pix_type;
   typedef pix_type [2:0][2:0] window_type;

   typedef struct packed {
      logic res_valid;
      logic interior;
      logic last;
   } pos_flags_type;

endpackage

### rtl/rif_pos_ctrl.sv
module rif_pos_ctrl #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     accept,
   input  logic [rif_pkg::CFG_WIDTH_BITS-1:0]       image_width,
   input  logic [rif_pkg::CFG_HEIGHT_BITS-1:0]      image_height,
   output logic [$clog2(MAX_WIDTH)-1:0]             in_col,
   output logic [$clog2(MAX_WIDTH)-1:0]             out_col,
   output rif_pkg::pos_flags_type                   flags
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int EW = (AW + 1 > rif_pkg::CFG_WIDTH_BITS) ? AW + 1 : rif_pkg::CFG_WIDTH_BITS;
   localparam int HW = rif_pkg::CFG_HEIGHT_BITS;

   logic [AW-1:0] in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [HW-1:0] in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic          primed_ff, primed_in;
   logic [EW-1:0] eff_w, in_col_next, out_col_next;
   logic [HW:0]   eff_h, out_row_next;
   logic          in_wrap, out_wrap, res_valid, interior, last;

   always_comb begin
      if (image_width == '0) begin
         eff_w = EW'(1);
      end else if (EW'(image_width) > EW'(MAX_WIDTH)) begin
         eff_w = EW'(MAX_WIDTH);
      end else begin
         eff_w = EW'(image_width);
      end
      eff_h = (image_height == '0) ? (HW+1)'(1) : {1'b0, image_height};
   end

   assign in_col_next  = EW'(in_col_ff) + EW'(1);
   assign out_col_next = EW'(out_col_ff) + EW'(1);
   assign out_row_next = {1'b0, out_row_ff} + (HW+1)'(1);
   assign in_wrap      = in_col_next >= eff_w;
   assign out_wrap     = out_col_next >= eff_w;

   // output starts once the window has seen a row plus one pixel
   assign res_valid = primed_ff || (in_row_ff >= HW'(2)) ||
                      ((in_row_ff == HW'(1)) && (in_col_ff != '0));
   assign interior  = (out_col_ff != '0) && !out_wrap && (out_row_ff != '0) &&
                      (out_row_next < eff_h);
   assign last      = (out_row_next >= eff_h) && out_wrap;

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      primed_in  = primed_ff;
      if (accept) begin
         if (in_wrap) begin
            in_col_in = '0;
            if (in_row_ff != '1) begin
               in_row_in = in_row_ff + HW'(1);
            end
         end else begin
            in_col_in = in_col_next[AW-1:0];
         end
         if (res_valid) begin
            primed_in = 1'b1;
            if (last) begin
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
               primed_in  = 1'b0;
            end else if (out_wrap) begin
               out_col_in = '0;
               if (out_row_ff != '1) begin
                  out_row_in = out_row_ff + HW'(1);
               end
            end else begin
               out_col_in = out_col_next[AW-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         primed_ff  <= 1'b0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         primed_ff  <= primed_in;
      end
   end

   assign in_col          = in_col_ff;
   assign out_col         = out_col_ff;
   assign flags.res_valid = res_valid;
   assign flags.interior  = interior;
   assign flags.last      = last;

endmodule

### rtl/rif_line_buf.sv
module rif_line_buf #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  rif_pkg::pix_type             pixel,
   input  logic [$clog2(MAX_WIDTH)-1:0] in_col,
   input  logic [$clog2(MAX_WIDTH)-1:0] out_col,
   input  rif_pkg::pos_flags_type       flags,
   output logic                         win_valid,
   output rif_pkg::window_type          window,
   output rif_pkg::pix_type             center,
   output rif_pkg::pos_flags_type       win_flags
);

   localparam int AW = $clog2(MAX_WIDTH);

   rif_pkg::pix_type upper_mem [MAX_WIDTH];
   rif_pkg::pix_type lower_mem [MAX_WIDTH];

   rif_pkg::pix_type       up_col_rd_ff, lo_col_rd_ff, up_out_rd_ff;
   rif_pkg::pix_type       up_col_eff, lo_col_eff, up_out_eff;
   rif_pkg::pix_type       fwd_up_ff, fwd_lo_ff;
   logic                   fwd_col_ff, fwd_out_ff;
   logic                   s1_valid_ff;
   rif_pkg::pix_type       s1_pix_ff;
   logic [AW-1:0]          s1_col_ff;
   rif_pkg::pos_flags_type s1_flags_ff;
   rif_pkg::window_type    window_ff, window_in;
   rif_pkg::pix_type       center_ff;
   rif_pkg::pos_flags_type win_flags_ff;
   logic                   win_valid_ff;

   // the item in s1 writes back while the next item reads
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         upper_mem[s1_col_ff] <= lo_col_eff;
      end
      up_col_rd_ff <= upper_mem[in_col];
      up_out_rd_ff <= upper_mem[out_col];
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         lower_mem[s1_col_ff] <= s1_pix_ff;
      end
      lo_col_rd_ff <= lower_mem[in_col];
   end

   // bypass the write that lands on the same edge as the read
   assign up_col_eff = fwd_col_ff ? fwd_up_ff : up_col_rd_ff;
   assign lo_col_eff = fwd_col_ff ? fwd_lo_ff : lo_col_rd_ff;
   assign up_out_eff = fwd_out_ff ? fwd_up_ff : up_out_rd_ff;

   always_comb begin
      window_in = window_ff;
      for (int i = 0; i < 3; i++) begin
         window_in[i][0] = window_ff[i][1];
         window_in[i][1] = window_ff[i][2];
      end
      window_in[0][2] = up_col_eff;
      window_in[1][2] = lo_col_eff;
      window_in[2][2] = s1_pix_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_col_ff   <= 1'b0;
         fwd_out_ff   <= 1'b0;
         win_valid_ff <= 1'b0;
         window_ff    <= '0;
      end else begin
         s1_valid_ff  <= accept;
         fwd_col_ff   <= s1_valid_ff && (s1_col_ff == in_col);
         fwd_out_ff   <= s1_valid_ff && (s1_col_ff == out_col);
         win_valid_ff <= s1_valid_ff && s1_flags_ff.res_valid;
         if (s1_valid_ff) begin
            window_ff <= window_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_pix_ff    <= pixel;
      s1_col_ff    <= in_col;
      s1_flags_ff  <= flags;
      fwd_up_ff    <= lo_col_eff;
      fwd_lo_ff    <= s1_pix_ff;
      center_ff    <= up_out_eff;
      win_flags_ff <= s1_flags_ff;
   end

   assign win_valid = win_valid_ff;
   assign window    = window_ff;
   assign center    = center_ff;
   assign win_flags = win_flags_ff;

endmodule

### rtl/rif_kernel.sv
module rif_kernel (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   input  rif_pkg::window_type                   window,
   input  rif_pkg::pix_type                      center,
   input  rif_pkg::pos_flags_type                flags,
   input  logic [rif_pkg::CFG_MODE_BITS-1:0]     filter_mode,
   input  logic [rif_pkg::CFG_MAXC_BITS-1:0]     max_color,
   output logic                                  out_valid,
   output rif_pkg::rsp_item_type                 out_item
);

   localparam int CB = rif_pkg::CHANNEL_BITS;
   localparam int KS = rif_pkg::KSUM_BITS;
   localparam int KM = rif_pkg::KMAG_BITS;
   localparam int GS = rif_pkg::GSUM_BITS;
   localparam int NC = rif_pkg::CHANNELS;

   function automatic logic signed [KS-1:0] widen(input logic [CB-1:0] v);
      return $signed({{(KS-CB){1'b0}}, v});
   endfunction

   function automatic logic signed [KS-1:0] kernel_sum(
      input logic [rif_pkg::CFG_MODE_BITS-1:0] mode,
      input rif_pkg::window_type               win,
      input int                                ch
   );
      logic signed [KS-1:0] t00, t01, t02, t10, t11, t12, t20, t21, t22, all9, res;
      t00 = widen(win[0][0][ch]);
      t01 = widen(win[0][1][ch]);
      t02 = widen(win[0][2][ch]);
      t10 = widen(win[1][0][ch]);
      t11 = widen(win[1][1][ch]);
      t12 = widen(win[1][2][ch]);
      t20 = widen(win[2][0][ch]);
      t21 = widen(win[2][1][ch]);
      t22 = widen(win[2][2][ch]);
      all9 = t00 + t01 + t02 + t10 + t11 + t12 + t20 + t21 + t22;
      case (mode)
         rif_pkg::MODE_EMBOSS:  res = (t11 + t12 + t21 + (t22 <<< 1)) - ((t00 <<< 1) + t01 + t10);
         rif_pkg::MODE_EDGE:    res = (t11 <<< 3) + t11 - all9;
         rif_pkg::MODE_BLUR:    res = all9;
         rif_pkg::MODE_SHARPEN: res = (t11 <<< 2) + t11 - (t01 + t10 + t12 + t21);
         default:               res = '0;
      endcase
      return res;
   endfunction

   function automatic logic [CB-1:0] kernel_clamp(
      input logic signed [KS-1:0] s,
      input logic                 blur,
      input logic [CB-1:0]        maxc
   );
      logic [KM-1:0]    mag, v;
      logic [KM+11:0]   prod;
      mag  = s[KS-1] ? '0 : s[KM-1:0];
      prod = (KM+12)'(mag) * (KM+12)'(rif_pkg::DIV9_MUL);
      v    = blur ? KM'(prod >> rif_pkg::DIV9_SHIFT) : mag;
      if (v > KM'(maxc)) begin
         return maxc;
      end
      return v[CB-1:0];
   endfunction

   logic [NC-1:0][KS-1:0]  ksum;
   logic [GS-1:0]          gsum;

   logic [NC-1:0][KS-1:0]  ksum_ff;
   logic [GS-1:0]          gsum_ff;
   rif_pkg::pix_type       center_ff;
   rif_pkg::pos_flags_type flags_ff;
   logic                   valid_ff;

   logic [GS+9:0]          gprod;
   logic [CB-1:0]          gray;
   rif_pkg::pix_type       kern, inv, res;

   always_comb begin
      for (int c = 0; c < NC; c++) begin
         ksum[c] = kernel_sum(filter_mode, window, c);
      end
      gsum = GS'(center[rif_pkg::CH_RED]) + GS'(center[rif_pkg::CH_GREEN]) +
             GS'(center[rif_pkg::CH_BLUE]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      ksum_ff   <= ksum;
      gsum_ff   <= gsum;
      center_ff <= center;
      flags_ff  <= flags;
   end

   assign gprod = (GS+10)'(gsum_ff) * (GS+10)'(rif_pkg::DIV3_MUL);
   assign gray  = CB'(gprod >> rif_pkg::DIV3_SHIFT);

   always_comb begin
      for (int c = 0; c < NC; c++) begin
         kern[c] = kernel_clamp($signed(ksum_ff[c]), filter_mode == rif_pkg::MODE_BLUR,
                                max_color);
         inv[c]  = (center_ff[c] > max_color) ? '0 : max_color - center_ff[c];
      end
   end

   always_comb begin
      case (filter_mode) inside
         rif_pkg::MODE_GRAY:   res = {NC{gray}};
         rif_pkg::MODE_INVERT: res = inv;
         rif_pkg::MODE_EMBOSS, rif_pkg::MODE_EDGE, rif_pkg::MODE_BLUR,
         rif_pkg::MODE_SHARPEN: res = flags_ff.interior ? kern : center_ff;
         default:              res = center_ff;
      endcase
   end

   assign out_valid          = valid_ff;
   assign out_item.red_out   = res[rif_pkg::CH_RED];
   assign out_item.green_out = res[rif_pkg::CH_GREEN];
   assign out_item.blue_out  = res[rif_pkg::CH_BLUE];
   assign out_item.frame_end = flags_ff.last;

endmodule

### rtl/rif_out_fifo.sv
module rif_out_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  credit_take,
   input  logic                  push,
   input  rif_pkg::rsp_item_type push_item,
   input  logic                  out_stall,
   output logic                  full,
   output logic                  out_valid,
   output rif_pkg::rsp_item_type out_item
);

   localparam int PB = rif_pkg::FIFO_PTR_BITS;
   localparam int CB = rif_pkg::FIFO_CNT_BITS;

   rif_pkg::rsp_item_type fifo_mem [rif_pkg::FIFO_DEPTH];

   logic [PB-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CB-1:0] fill_ff, credit_ff;
   logic          pop;

   assign pop = out_valid && !out_stall;

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_mem[wr_ptr_ff] <= push_item;
      end
   end

   // credits cover every accepted item that still owes a result
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
         credit_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PB'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PB'(1);
         end
         fill_ff   <= fill_ff + CB'(push) - CB'(pop);
         credit_ff <= credit_ff + CB'(credit_take) - CB'(pop);
      end
   end

   assign full      = credit_ff >= CB'(rif_pkg::FIFO_DEPTH);
   assign out_valid = fill_ff != '0;
   assign out_item  = fifo_mem[rd_ptr_ff];

endmodule

### rtl/rgb_image_filter_3x3.sv
// streaming 3x3 rgb filter, one item accepted per clock when the output keeps up
// results lag the pixel stream by image_width+1 items; once the item completing its window
// is accepted, its result passes the memory read, window and sum registers and then the output queue
// an 8-entry output queue lets input run ahead; input stalls only with 8 results owed
// reset: registers to defaults, counters, window and queue cleared; line memories are not
// cleared and hold whatever was last written
module rgb_image_filter_3x3 #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  rif_pkg::req_item_type                req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output rif_pkg::rsp_item_type                rsp_data,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [rif_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [rif_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [rif_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                 csr_pready
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int DB = rif_pkg::CSR_DATA_BITS;

   logic [rif_pkg::CFG_MODE_BITS-1:0]   filter_mode_ff;
   logic [rif_pkg::CFG_WIDTH_BITS-1:0]  image_width_ff;
   logic [rif_pkg::CFG_HEIGHT_BITS-1:0] image_height_ff;
   logic [rif_pkg::CFG_MAXC_BITS-1:0]   max_color_ff;
   logic                                csr_write;
   rif_pkg::csr_reg_type                csr_index;

   logic                   accept;
   rif_pkg::pix_type       pixel;
   logic [AW-1:0]          in_col, out_col;
   rif_pkg::pos_flags_type flags, win_flags;
   logic                   win_valid;
   rif_pkg::window_type    window;
   rif_pkg::pix_type       center;
   logic                   res_valid;
   rif_pkg::rsp_item_type  res_item;
   logic                   queue_full;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = rif_pkg::csr_reg_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_mode_ff  <= rif_pkg::MODE_RESET;
         image_width_ff  <= rif_pkg::WIDTH_RESET;
         image_height_ff <= rif_pkg::HEIGHT_RESET;
         max_color_ff    <= rif_pkg::MAXC_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            rif_pkg::REG_FILTER_MODE:
               filter_mode_ff <= csr_pwdata[rif_pkg::CFG_MODE_BITS-1:0];
            rif_pkg::REG_IMAGE_WIDTH:
               image_width_ff <= csr_pwdata[rif_pkg::CFG_WIDTH_BITS-1:0];
            rif_pkg::REG_IMAGE_HEIGHT:
               image_height_ff <= csr_pwdata[rif_pkg::CFG_HEIGHT_BITS-1:0];
            rif_pkg::REG_MAX_COLOR:
               max_color_ff <= csr_pwdata[rif_pkg::CFG_MAXC_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         rif_pkg::REG_FILTER_MODE:  csr_prdata = DB'(filter_mode_ff);
         rif_pkg::REG_IMAGE_WIDTH:  csr_prdata = DB'(image_width_ff);
         rif_pkg::REG_IMAGE_HEIGHT: csr_prdata = DB'(image_height_ff);
         rif_pkg::REG_MAX_COLOR:    csr_prdata = DB'(max_color_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   // input side, drain items enter as black pixels
   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      pixel = '0;
      if (!req_data.drain) begin
         pixel[rif_pkg::CH_RED]   = req_data.red_in;
         pixel[rif_pkg::CH_GREEN] = req_data.green_in;
         pixel[rif_pkg::CH_BLUE]  = req_data.blue_in;
      end
   end

   rif_pos_ctrl #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_pos_ctrl (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .image_width  (image_width_ff),
      .image_height (image_height_ff),
      .in_col       (in_col),
      .out_col      (out_col),
      .flags        (flags)
   );

   rif_line_buf #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_buf (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .pixel     (pixel),
      .in_col    (in_col),
      .out_col   (out_col),
      .flags     (flags),
      .win_valid (win_valid),
      .window    (window),
      .center    (center),
      .win_flags (win_flags)
   );

   rif_kernel u_kernel (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (win_valid),
      .window      (window),
      .center      (center),
      .flags       (win_flags),
      .filter_mode (filter_mode_ff),
      .max_color   (max_color_ff),
      .out_valid   (res_valid),
      .out_item    (res_item)
   );

   rif_out_fifo u_out_fifo (
      .clock       (clock),
      .reset       (reset),
      .credit_take (accept && flags.res_valid),
      .push        (res_valid),
      .push_item   (res_item),
      .out_stall   (rsp_stall),
      .full        (queue_full),
      .out_valid   (rsp_valid),
      .out_item    (rsp_data)
   );

endmodule
